/* rtl/wav_header_checker_core_macros.svh */
// ----------------------------------------------------------------------------
// WAV header checker assertion macros
// Short forms for the clocked assertions used by the checker module.
// ----------------------------------------------------------------------------
`ifndef WAV_HEADER_CHECKER_CORE_MACROS_SVH
`define WAV_HEADER_CHECKER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WHC_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("wav header checker: same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define WHC_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("wav header checker: next-cycle assertion failed");

`endif

/* rtl/whc_pkg.sv */
// ----------------------------------------------------------------------------
// WAV header checker package
// Word types, status codes and tag constants shared by the core and checker.
// ----------------------------------------------------------------------------
`default_nettype none

package whc_pkg;

	// Default width of the byte position counter.
	localparam int POSITION_BITS_DEF = 32;

	// Result status codes, in the order in which they are checked.
	localparam logic [2:0] STAT_OK           = 3'd0;
	localparam logic [2:0] STAT_MISSING      = 3'd1;
	localparam logic [2:0] STAT_NOT_PCM      = 3'd2;
	localparam logic [2:0] STAT_BAD_CHAN     = 3'd3;
	localparam logic [2:0] STAT_INCONSISTENT = 3'd4;
	localparam logic [2:0] STAT_BAD_DEPTH    = 3'd5;

	// Three-byte chunk tags, first byte in the high bits.
	localparam logic [23:0] TAG_FMT = 24'h666D74;
	localparam logic [23:0] TAG_DAT = 24'h646174;

	// Format code of uncompressed PCM.
	localparam logic [15:0] FMT_PCM = 16'd1;

	// Input word: one byte of the file.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_file;
	} src_word_t;

	// Result word: one per file.
	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] rate_hz;
		logic [15:0] channel_count;
		logic [15:0] depth_bits;
		logic [31:0] sample_frames;
		logic [31:0] samples_offset;
	} res_word_t;

endpackage

`default_nettype wire

/* rtl/wav_header_checker_core.sv */
// ----------------------------------------------------------------------------
// WAV header checker core
// Scans a RIFF/WAVE byte stream for the format and data chunks, captures the
// header fields and reports a status word with the main values per file.
// ----------------------------------------------------------------------------
// Bytes of a file are taken one per cycle while the input is not stalled. When
// the word marked end_of_file is accepted, the core stalls its input while a small
// sequencer runs the final checks on one shared 33-bit adder: the early checks,
// 32 shift-and-add steps for the byte-rate product, the rate, align and depth
// checks and 32 restoring-division steps for the frame count, then the load of
// the result register, which waits while the previous result is still not taken.
// The input stays stalled until that load; failed early checks go to it at once
// and failed product or depth checks go to it without the division.
// The next file may stream in while a result waits.
// A result is given only for the final byte.
`default_nettype none

module wav_header_checker_core #(
	parameter int POSITION_BITS = whc_pkg::POSITION_BITS_DEF
) (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic src_valid,
	output                     logic src_stall,
	input  wire whc_pkg::src_word_t  src_data,
	output                     logic res_valid,
	input  wire                logic res_stall,
	output whc_pkg::res_word_t       res_data
);

	// Sequencer states.
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PREP = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_CHK  = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	// Both loops run over a 32-bit operand.
	localparam int STEPS = 32;
	localparam int CNT_W = $clog2(STEPS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

	// Offsets of the capture windows relative to a tag.
	localparam logic [POSITION_BITS-1:0] FMT_LO  = POSITION_BITS'(8);
	localparam logic [POSITION_BITS-1:0] FMT_HI  = POSITION_BITS'(23);
	localparam logic [POSITION_BITS-1:0] DAT_LO  = POSITION_BITS'(4);
	localparam logic [POSITION_BITS-1:0] DAT_HI  = POSITION_BITS'(7);
	localparam logic [POSITION_BITS-1:0] TAG_LAG = POSITION_BITS'(2);
	localparam logic [POSITION_BITS-1:0] SMP_OFF = POSITION_BITS'(8);
	localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

	// Scan state.
	logic [2:0]               state_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [15:0]              recent_q;
	logic                     fmt_seen_q;
	logic [POSITION_BITS-1:0] fmt_at_q;
	logic                     dat_seen_q;
	logic [POSITION_BITS-1:0] dat_at_q;
	logic [127:0]             fmt_q;
	logic [31:0]              dsz_q;

	// Arithmetic sequencer state.
	logic [31:0]      acc_q;
	logic [31:0]      mcand_q;
	logic [31:0]      mplier_q;
	logic [CNT_W-1:0] cnt_q;
	logic [2:0]       rem_q;
	logic [31:0]      quot_q;
	logic [2:0]       div_q;
	logic [2:0]       stat_q;

	// Result register.
	logic               res_valid_q;
	whc_pkg::res_word_t res_q;

	// Views of the captured format fields.
	logic [15:0] f_audio;
	logic [15:0] f_chan;
	logic [31:0] f_rate;
	logic [31:0] f_bps;
	logic [15:0] f_block;
	logic [15:0] f_depth;

	assign f_audio = fmt_q[15:0];
	assign f_chan  = fmt_q[31:16];
	assign f_rate  = fmt_q[63:32];
	assign f_bps   = fmt_q[95:64];
	assign f_block = fmt_q[111:96];
	assign f_depth = fmt_q[127:112];

	// Start of the samples, wrapping with the position counter.
	logic [POSITION_BITS-1:0] smp_at;
	assign smp_at = dat_at_q + SMP_OFF;

	logic accept;
	assign src_stall = (state_q != S_IDLE);
	assign accept    = src_valid && !src_stall;

	// Capture of the current byte into the field registers.
	logic [POSITION_BITS-1:0] fmt_off;
	logic [POSITION_BITS-1:0] dat_off;
	logic                     fmt_hit;
	logic                     dat_hit;
	logic [3:0]               fmt_k;
	logic [1:0]               dat_k;
	logic [127:0]             fmt_nxt;
	logic [31:0]              dsz_nxt;
	logic [23:0]              window;

	always_comb begin
		fmt_off = pos_q - fmt_at_q;
		dat_off = pos_q - dat_at_q;
		fmt_hit = fmt_seen_q && (fmt_off >= FMT_LO) && (fmt_off <= FMT_HI);
		dat_hit = dat_seen_q && (dat_off >= DAT_LO) && (dat_off <= DAT_HI);
		fmt_k   = fmt_off[3:0] - 4'd8;
		dat_k   = dat_off[1:0];
		fmt_nxt = fmt_q;
		dsz_nxt = dsz_q;
		for (int i = 0; i < 16; i++) begin
			if (fmt_hit && (fmt_k == 4'(i))) begin
				fmt_nxt[i*8 +: 8] = fmt_q[i*8 +: 8] | src_data.data_byte;
			end
		end
		for (int j = 0; j < 4; j++) begin
			if (dat_hit && (dat_k == 2'(j))) begin
				dsz_nxt[j*8 +: 8] = dsz_q[j*8 +: 8] | src_data.data_byte;
			end
		end
		window = {recent_q, src_data.data_byte};
	end

	// Shared adder: accumulates in the multiply, trial-subtracts in the divide.
	logic [31:0] alu_a;
	logic [31:0] alu_b;
	logic        alu_sub;
	logic [32:0] alu_sum;

	always_comb begin
		alu_a   = acc_q;
		alu_b   = mcand_q;
		alu_sub = 1'b0;
		if (state_q == S_DIV) begin
			alu_a   = {28'd0, rem_q, quot_q[31]};
			alu_b   = {29'd0, div_q};
			alu_sub = 1'b1;
		end
		alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + {32'd0, alu_sub};
	end

	// Rate, align and depth checks on the finished product.
	logic        bps_ok;
	logic [15:0] per_sample;
	logic [16:0] align_want;
	logic        block_ok;
	logic        depth_ok;
	logic [2:0]  block_bytes;

	always_comb begin
		bps_ok     = ({3'b000, acc_q[31:3]} == f_bps);
		// Division by eight, truncating toward zero for a negative depth.
		per_sample = 16'($signed(f_depth) >>> 3)
			+ {15'd0, (f_depth[15] && (f_depth[2:0] != 3'd0))};
		align_want = f_chan[1] ? {per_sample, 1'b0} : {per_sample[15], per_sample};
		block_ok   = ({f_block[15], f_block} == align_want);
		depth_ok   = (f_depth == 16'd8) || (f_depth == 16'd16) || (f_depth == 16'd24);
		block_bytes = f_chan[1] ? {f_depth[4:3], 1'b0} : {1'b0, f_depth[4:3]};
	end

	// Main sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pos_q       <= '0;
			recent_q    <= '0;
			fmt_seen_q  <= 1'b0;
			fmt_at_q    <= '0;
			dat_seen_q  <= 1'b0;
			dat_at_q    <= '0;
			fmt_q       <= '0;
			dsz_q       <= '0;
			res_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			// The result word leaves when the far side takes it, unless a new
			// one is loaded in the same cycle.
			if (res_valid_q && !res_stall && (state_q != S_FIN)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						fmt_q    <= fmt_nxt;
						dsz_q    <= dsz_nxt;
						recent_q <= window[15:0];
						pos_q    <= pos_q + POS_ONE;
						if (src_data.end_of_file) begin
							state_q <= S_PREP;
						end else begin
							if (!fmt_seen_q && (window == whc_pkg::TAG_FMT)) begin
								fmt_seen_q <= 1'b1;
								fmt_at_q   <= pos_q - TAG_LAG;
							end
							if (!dat_seen_q && (window == whc_pkg::TAG_DAT)) begin
								dat_seen_q <= 1'b1;
								dat_at_q   <= pos_q - TAG_LAG;
							end
						end
					end
				end
				S_PREP: begin
					quot_q <= '0;
					if (!fmt_seen_q || !dat_seen_q) begin
						stat_q  <= whc_pkg::STAT_MISSING;
						state_q <= S_FIN;
					end else if (f_audio != whc_pkg::FMT_PCM) begin
						stat_q  <= whc_pkg::STAT_NOT_PCM;
						state_q <= S_FIN;
					end else if ((f_chan != 16'd1) && (f_chan != 16'd2)) begin
						stat_q  <= whc_pkg::STAT_BAD_CHAN;
						state_q <= S_FIN;
					end else begin
						acc_q    <= '0;
						mcand_q  <= f_chan[1] ? {f_rate[30:0], 1'b0} : f_rate;
						mplier_q <= {{16{f_depth[15]}}, f_depth};
						cnt_q    <= '0;
						state_q  <= S_MUL;
					end
				end
				S_MUL: begin
					// One shift-and-add step of the product modulo 2^32.
					if (mplier_q[0]) begin
						acc_q <= alu_sum[31:0];
					end
					mcand_q  <= {mcand_q[30:0], 1'b0};
					mplier_q <= {1'b0, mplier_q[31:1]};
					cnt_q    <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_LAST) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (!bps_ok || !block_ok) begin
						stat_q  <= whc_pkg::STAT_INCONSISTENT;
						state_q <= S_FIN;
					end else if (!depth_ok) begin
						stat_q  <= whc_pkg::STAT_BAD_DEPTH;
						state_q <= S_FIN;
					end else begin
						stat_q  <= whc_pkg::STAT_OK;
						div_q   <= block_bytes;
						rem_q   <= '0;
						quot_q  <= dsz_q;
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					// One restoring-division step; the carry means no borrow.
					quot_q <= {quot_q[30:0], alu_sum[32]};
					rem_q  <= alu_sum[32] ? alu_sum[2:0] : {rem_q[1:0], quot_q[31]};
					cnt_q  <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_LAST) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!res_valid_q || !res_stall) begin
						res_valid_q          <= 1'b1;
						res_q.status         <= stat_q;
						res_q.rate_hz        <= f_rate;
						res_q.channel_count  <= f_chan;
						res_q.depth_bits     <= f_depth;
						res_q.sample_frames  <= quot_q;
						res_q.samples_offset <= dat_seen_q ? 32'(smp_at) : 32'd0;
						// Start the next file from a clean scan state.
						pos_q      <= '0;
						recent_q   <= '0;
						fmt_seen_q <= 1'b0;
						fmt_at_q   <= '0;
						dat_seen_q <= 1'b0;
						dat_at_q   <= '0;
						fmt_q      <= '0;
						dsz_q      <= '0;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

`default_nettype wire

/* rtl/whc_checker.sv */
// ----------------------------------------------------------------------------
// WAV header checker port checks
// Watches the core's ports over time and is bound to the core module below.
// ----------------------------------------------------------------------------
`default_nettype none

`include "wav_header_checker_core_macros.svh"

module whc_checker (
	input wire                logic clk,
	input wire                logic arst_n,
	input wire                logic src_valid,
	input wire                logic src_stall,
	input wire whc_pkg::src_word_t  src_data,
	input wire                logic res_valid,
	input wire                logic res_stall,
	input wire whc_pkg::res_word_t  res_data
);

	// The final byte of a file is taken at this edge.
	logic src_take_last;
	assign src_take_last = src_valid && !src_stall && src_data.end_of_file;

	// A result word is offered with a status other than ok.
	logic res_not_ok;
	assign res_not_ok = res_valid && (res_data.status != whc_pkg::STAT_OK);

	// A result word waiting to be taken stays offered.
	`WHC_ASSERT_NEXT(a_res_held, res_valid && res_stall, res_valid)

	// The final byte of a file starts the checks, which hold the input back.
	`WHC_ASSERT_NEXT(a_busy_after_last, src_take_last, src_stall)

	// Only the defined status codes are reported.
	`WHC_ASSERT_NOW(a_status_code, res_valid, res_data.status <= whc_pkg::STAT_BAD_DEPTH)

	// A frame count is given only for a file that passed every check.
	`WHC_ASSERT_NOW(a_frames_only_ok, res_not_ok, res_data.sample_frames == 32'd0)

endmodule

bind wav_header_checker_core whc_checker u_whc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.src_valid (src_valid),
	.src_stall (src_stall),
	.src_data  (src_data),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_data  (res_data)
);

`default_nettype wire

/* tb/tb_wav_header_checker_core.sv */
// ----------------------------------------------------------------------------
// WAV header checker core testbench
// Streams RIFF/WAVE files into the core one byte word at a time and compares
// each per-file result word with a local header predictor. A short table of
// directed files covers every status code, the field extremes, truncated and
// tagless files; random files with well-formed headers, random fields,
// truncation and plain noise follow. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_wav_header_checker_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DIR_ROWS     = 25;
	localparam int RANDOM_BYTES = 200;
	localparam int RANDOM_FILES = 5;
	localparam int CYCLE_LIMIT  = 200000;

	// Chunk identifiers as they appear in the file, first character high.
	localparam logic [31:0] RIFF_TEXT = "RIFF";
	localparam logic [31:0] WAVE_TEXT = "WAVE";
	localparam logic [31:0] FMT_TEXT  = {whc_pkg::TAG_FMT, 8'h20};
	localparam logic [31:0] DATA_TEXT = {whc_pkg::TAG_DAT, 8'h61};
	// Spoilt identifiers: the second character is replaced by an 'x'.
	localparam logic [31:0] FMT_SPOILT  = {whc_pkg::TAG_FMT[23:16], 8'h78,
			whc_pkg::TAG_FMT[7:0], 8'h20};
	localparam logic [31:0] DATA_SPOILT = {whc_pkg::TAG_DAT[23:16], 8'h78,
			whc_pkg::TAG_DAT[7:0], 8'h61};

	// One file to stream: header values, layout and, where typed, the result.
	typedef struct packed {
		logic [15:0] audio;
		logic [15:0] chan;
		logic [31:0] rate;
		logic [31:0] byte_rate;
		logic [15:0] align;
		logic [15:0] depth;
		logic [31:0] size;
		logic [7:0]  pad_a;
		logic [7:0]  pad_b;
		logic [15:0] len;
		logic        no_fmt;
		logic        no_dat;
		logic        noise;
		logic        typed;
		logic [2:0]  want_status;
		logic [31:0] want_frames;
	} wav_file_t;

	// Per-file note: whether the result was typed into the table, and its value.
	typedef struct packed {
		logic               typed;
		whc_pkg::res_word_t want;
	} file_note_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               src_valid = 1'b0;
	whc_pkg::src_word_t src_data  = '0;
	logic               res_stall = 1'b0;
	logic               src_stall;
	logic               res_valid;
	whc_pkg::res_word_t res_data;

	wav_header_checker_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_data  (src_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	// Header predictor state.
	logic [31:0] hp_pos;
	logic [23:0] hp_recent;
	bit          hp_fmt_seen;
	logic [31:0] hp_fmt_at;
	bit          hp_dat_seen;
	logic [31:0] hp_dat_at;
	logic [63:0] hp_fmt_fields [2];
	logic [31:0] hp_data_size;

	wav_file_t          dir_tab [DIR_ROWS];
	logic [7:0]         file_bytes [$];
	file_note_t         file_notes [$];
	whc_pkg::res_word_t wav_results_due [$];

	bit                 calm = 1'b0;
	int                 bytes_sent = 0;
	int                 mismatch_count = 0;
	int                 cycle_count = 0;
	bit                 header_done;
	whc_pkg::res_word_t header_result;
	whc_pkg::res_word_t due_word;
	file_note_t         taken_note;

	// Free-running clock.
	initial begin
		forever #10 clk = ~clk;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic clear_header_state();
		hp_pos           = '0;
		hp_recent        = '0;
		hp_fmt_seen      = 1'b0;
		hp_fmt_at        = '0;
		hp_dat_seen      = 1'b0;
		hp_dat_at        = '0;
		hp_fmt_fields[0] = '0;
		hp_fmt_fields[1] = '0;
		hp_data_size     = '0;
	endtask

	// Advances the header predictor by one byte word; on the final byte it
	// yields the result word and clears its state for the next file.
	task automatic predict_header_byte(input whc_pkg::src_word_t w, output bit done,
			output whc_pkg::res_word_t r);
		logic [31:0] p;
		logic [31:0] off;
		logic [31:0] k;
		logic [23:0] window;
		logic [15:0] audio;
		logic [15:0] chan;
		logic [15:0] block;
		logic [15:0] depth;
		logic [31:0] rate;
		logic [31:0] bps;
		logic [31:0] prod;
		logic [31:0] divisor;
		logic [31:0] frames;
		logic [2:0]  stat;
		int          chan_s;
		int          depth_s;
		int          block_s;
		p    = hp_pos;
		done = 1'b0;
		r    = '0;
		// Captures are relative to tags found on earlier bytes.
		if (hp_fmt_seen) begin
			off = p - hp_fmt_at;
			if (off >= 8 && off <= 23) begin
				k = off - 32'd8;
				hp_fmt_fields[k[3]] = hp_fmt_fields[k[3]] |
						({56'd0, w.data_byte} << (k[2:0] * 8));
			end
		end
		if (hp_dat_seen) begin
			off = p - hp_dat_at;
			if (off >= 4 && off <= 7)
				hp_data_size = hp_data_size | ({24'd0, w.data_byte} << ((off - 4) * 8));
		end
		// Tag search; a match completing on the final byte does not count.
		window    = {hp_recent[15:0], w.data_byte};
		hp_recent = window;
		if (!w.end_of_file) begin
			if (!hp_fmt_seen && window == whc_pkg::TAG_FMT) begin
				hp_fmt_seen = 1'b1;
				hp_fmt_at   = p - 32'd2;
			end
			if (!hp_dat_seen && window == whc_pkg::TAG_DAT) begin
				hp_dat_seen = 1'b1;
				hp_dat_at   = p - 32'd2;
			end
		end
		hp_pos = p + 32'd1;
		if (w.end_of_file) begin
			audio   = hp_fmt_fields[0][15:0];
			chan    = hp_fmt_fields[0][31:16];
			rate    = hp_fmt_fields[0][63:32];
			bps     = hp_fmt_fields[1][31:0];
			block   = hp_fmt_fields[1][47:32];
			depth   = hp_fmt_fields[1][63:48];
			chan_s  = $signed(chan);
			depth_s = $signed(depth);
			block_s = $signed(block);
			frames  = '0;
			// Checks in the order of the status codes.
			if (!hp_fmt_seen || !hp_dat_seen) begin
				stat = whc_pkg::STAT_MISSING;
			end else if (audio != whc_pkg::FMT_PCM) begin
				stat = whc_pkg::STAT_NOT_PCM;
			end else if (chan_s < 1 || chan_s > 2) begin
				stat = whc_pkg::STAT_BAD_CHAN;
			end else begin
				prod = $unsigned(chan_s) * rate * $unsigned(depth_s);
				if ((prod >> 3) != bps || block_s != chan_s * (depth_s / 8)) begin
					stat = whc_pkg::STAT_INCONSISTENT;
				end else if (depth != 16'd8 && depth != 16'd16 && depth != 16'd24) begin
					stat = whc_pkg::STAT_BAD_DEPTH;
				end else begin
					stat    = whc_pkg::STAT_OK;
					divisor = ({16'd0, chan} * {16'd0, depth}) >> 3;
					frames  = (divisor != 0) ? hp_data_size / divisor : '0;
				end
			end
			r.status         = stat;
			r.rate_hz        = rate;
			r.channel_count  = chan;
			r.depth_bits     = depth;
			r.sample_frames  = frames;
			r.samples_offset = hp_dat_seen ? hp_dat_at + 32'd8 : '0;
			done = 1'b1;
			clear_header_state();
		end
	endtask

	task automatic compare_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected 0x%0h got 0x%0h", $time, field, want, got);
			mismatch_count++;
		end
	endtask

	// Prediction on every accepted byte word, checking on every result word.
	always @(posedge clk) begin
		if (arst_n) begin
			if (src_valid && !src_stall) begin
				predict_header_byte(src_data, header_done, header_result);
				if (header_done) begin
					taken_note = file_notes.pop_front();
					wav_results_due.push_back(taken_note.typed ? taken_note.want :
							header_result);
				end
			end
			if (res_valid && !res_stall) begin
				if (wav_results_due.size() == 0) begin
					$display("%0t: result word with none expected: status %0d",
							$time, res_data.status);
					mismatch_count++;
				end else begin
					due_word = wav_results_due.pop_front();
					compare_field("status", 32'(due_word.status), 32'(res_data.status));
					compare_field("rate_hz", due_word.rate_hz, res_data.rate_hz);
					compare_field("channel_count", 32'(due_word.channel_count),
							32'(res_data.channel_count));
					compare_field("depth_bits", 32'(due_word.depth_bits),
							32'(res_data.depth_bits));
					compare_field("sample_frames", due_word.sample_frames,
							res_data.sample_frames);
					compare_field("samples_offset", due_word.samples_offset,
							res_data.samples_offset);
				end
			end
		end
	end

	// Result side stalls at random, except during the calm stretch.
	initial begin
		forever begin
			@(posedge clk);
			res_stall <= !calm && ($urandom_range(99) < 24);
		end
	end

	task automatic put_le(input logic [31:0] v, input int n);
		int i;
		for (i = 0; i < n; i++)
			file_bytes.push_back(v[i * 8 +: 8]);
	endtask

	task automatic put_text(input logic [31:0] v);
		file_bytes.push_back(v[31:24]);
		file_bytes.push_back(v[23:16]);
		file_bytes.push_back(v[15:8]);
		file_bytes.push_back(v[7:0]);
	endtask

	// Lays out the bytes of one file: canonical header with optional padding
	// before each chunk, then cut or extended with sample bytes to its length.
	task automatic build_file(input wav_file_t f);
		int          at;
		logic [23:0] tag;
		file_bytes.delete();
		if (f.noise) begin
			repeat (f.len) file_bytes.push_back(8'($urandom_range(255)));
			if (f.len >= 3 && $urandom_range(1)) begin
				at  = $urandom_range(32'(f.len) - 3);
				tag = $urandom_range(1) ? whc_pkg::TAG_FMT : whc_pkg::TAG_DAT;
				file_bytes[at]     = tag[23:16];
				file_bytes[at + 1] = tag[15:8];
				file_bytes[at + 2] = tag[7:0];
			end
		end else begin
			put_text(RIFF_TEXT);
			put_le(32'(f.len) - 32'd8, 4);
			put_text(WAVE_TEXT);
			repeat (f.pad_a) file_bytes.push_back(8'($urandom_range(255)));
			put_text(f.no_fmt ? FMT_SPOILT : FMT_TEXT);
			put_le(32'd16, 4);
			put_le({16'd0, f.audio}, 2);
			put_le({16'd0, f.chan}, 2);
			put_le(f.rate, 4);
			put_le(f.byte_rate, 4);
			put_le({16'd0, f.align}, 2);
			put_le({16'd0, f.depth}, 2);
			repeat (f.pad_b) file_bytes.push_back(8'($urandom_range(255)));
			put_text(f.no_dat ? DATA_SPOILT : DATA_TEXT);
			put_le(f.size, 4);
			while (file_bytes.size() > f.len)
				void'(file_bytes.pop_back());
			while (file_bytes.size() < f.len)
				file_bytes.push_back(8'($urandom_range(255)));
		end
	endtask

	// Streams one file, idling at random between byte words.
	task automatic send_file(input wav_file_t f);
		file_note_t         note;
		whc_pkg::src_word_t w;
		int                 i;
		build_file(f);
		note.typed                = f.typed;
		note.want.status          = f.want_status;
		note.want.rate_hz         = f.no_fmt ? '0 : f.rate;
		note.want.channel_count   = f.no_fmt ? '0 : f.chan;
		note.want.depth_bits      = f.no_fmt ? '0 : f.depth;
		note.want.sample_frames   = f.want_frames;
		note.want.samples_offset  = 32'(44 + f.pad_a + f.pad_b);
		file_notes.push_back(note);
		for (i = 0; i < file_bytes.size(); i++) begin
			w.data_byte   = file_bytes[i];
			w.end_of_file = (i == file_bytes.size() - 1);
			while (!calm && $urandom_range(99) < 24) begin
				src_valid <= 1'b0;
				@(posedge clk);
			end
			src_valid <= 1'b1;
			src_data  <= w;
			do @(posedge clk); while (src_stall);
			bytes_sent++;
		end
	endtask

	// Sender holds off until every outstanding result word has been taken.
	task automatic hold_until_drained();
		src_valid <= 1'b0;
		do @(posedge clk); while (wav_results_due.size() != 0);
	endtask

	// Random file: mostly well-formed headers with random content, the rest
	// random fields, truncated files and noise.
	function automatic wav_file_t random_wav_file();
		wav_file_t f;
		int        kind;
		int        full;
		f    = '0;
		kind = $urandom_range(99);
		f.pad_a = ($urandom_range(3) == 0) ? 8'($urandom_range(1, 12)) : 8'd0;
		f.pad_b = ($urandom_range(3) == 0) ? 8'($urandom_range(1, 12)) : 8'd0;
		f.audio = ($urandom_range(9) != 0) ? whc_pkg::FMT_PCM :
				16'($urandom_range(16'hFFFF));
		f.chan  = ($urandom_range(7) != 0) ? 16'($urandom_range(1, 2)) :
				16'($urandom_range(16'hFFFF));
		case ($urandom_range(6))
			0: f.rate = 32'd8000;
			1: f.rate = 32'd11025;
			2: f.rate = 32'd22050;
			3: f.rate = 32'd44100;
			4: f.rate = 32'd48000;
			5: f.rate = 32'd96000;
			default: f.rate = $urandom();
		endcase
		case ($urandom_range(9))
			0, 1, 2: f.depth = 16'd8;
			3, 4, 5: f.depth = 16'd16;
			6, 7: f.depth = 16'd24;
			8: f.depth = 16'($urandom_range(40));
			default: f.depth = 16'($urandom_range(16'hFFFF));
		endcase
		f.byte_rate = ($urandom_range(9) != 0) ?
				({16'd0, f.chan} * f.rate * {16'd0, f.depth}) >> 3 : $urandom();
		f.align = ($urandom_range(9) != 0) ? f.chan * (f.depth >> 3) :
				16'($urandom_range(16'hFFFF));
		f.size  = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(20000);
		full    = 44 + f.pad_a + f.pad_b;
		f.len   = 16'(full + $urandom_range(12));
		f.no_fmt = ($urandom_range(29) == 0);
		f.no_dat = ($urandom_range(29) == 0);
		if (kind < 15) begin
			f.audio     = 16'($urandom());
			f.chan      = 16'($urandom());
			f.rate      = $urandom();
			f.byte_rate = $urandom();
			f.align     = 16'($urandom());
			f.depth     = 16'($urandom());
		end else if (kind < 28) begin
			f.len = 16'($urandom_range(1, full));
		end else if (kind < 40) begin
			f.noise = 1'b1;
			f.len   = 16'($urandom_range(1, 48));
		end
		return f;
	endfunction

	// Stimulus and verdict.
	initial begin
		int row;
		int file_idx;
		clear_header_state();
		// Directed files. Typed rows carry the result; the rest use the predictor.
		//              audio  chan  rate  byte rate  align depth size  pads len
		//              no_fmt no_dat noise typed status frames
		dir_tab[0]  = '{1, 2, 44100, 176400, 4, 16, 4000, 0, 0, 48,
				0, 0, 0, 1, whc_pkg::STAT_OK, 1000};
		dir_tab[1]  = '{1, 1, 8000, 8000, 1, 8, 32'hFFFF_FFFF, 0, 0, 44,
				0, 0, 0, 1, whc_pkg::STAT_OK, 32'hFFFF_FFFF};
		dir_tab[2]  = '{1, 2, 96000, 576000, 6, 24, 600, 0, 0, 44,
				0, 0, 0, 1, whc_pkg::STAT_OK, 100};
		dir_tab[3]  = '{3, 2, 44100, 176400, 4, 16, 4000, 0, 0, 44,
				0, 0, 0, 1, whc_pkg::STAT_NOT_PCM, 0};
		dir_tab[4]  = '{16'hFFFF, 2, 44100, 176400, 4, 16, 4000, 0, 0, 44,
				0, 0, 0, 1, whc_pkg::STAT_NOT_PCM, 0};
		dir_tab[5]  = '{0, 2, 44100, 176400, 4, 16, 4000, 0, 0, 44,
				0, 0, 0, 1, whc_pkg::STAT_NOT_PCM, 0};
		dir_tab[6]  = '{1, 0, 44100, 0, 0, 16, 4000, 0, 0, 44,
				0, 0, 0, 1, whc_pkg::STAT_BAD_CHAN, 0};
		dir_tab[7]  = '{1, 3, 44100, 264600, 6, 16, 4000, 0, 0, 44,
				0, 0, 0, 1, whc_pkg::STAT_BAD_CHAN, 0};
		dir_tab[8]  = '{1, 16'hFFFF, 44100, 176400, 4, 16, 4000, 0, 0, 44,
				0, 0, 0, 1, whc_pkg::STAT_BAD_CHAN, 0};
		dir_tab[9]  = '{1, 2, 44100, 176401, 4, 16, 4000, 0, 0, 44,
				0, 0, 0, 1, whc_pkg::STAT_INCONSISTENT, 0};
		dir_tab[10] = '{1, 2, 44100, 176400, 2, 16, 4000, 0, 0, 44,
				0, 0, 0, 1, whc_pkg::STAT_INCONSISTENT, 0};
		dir_tab[11] = '{1, 1, 8000, 12000, 1, 12, 4000, 0, 0, 44,
				0, 0, 0, 1, whc_pkg::STAT_BAD_DEPTH, 0};
		dir_tab[12] = '{1, 2, 1000, 8000, 8, 32, 4000, 0, 0, 44,
				0, 0, 0, 1, whc_pkg::STAT_BAD_DEPTH, 0};
		dir_tab[13] = '{1, 1, 8000, 0, 0, 0, 4000, 0, 0, 44,
				0, 0, 0, 1, whc_pkg::STAT_BAD_DEPTH, 0};
		dir_tab[14] = '{1, 2, 0, 0, 4, 16, 8, 0, 0, 44,
				0, 0, 0, 1, whc_pkg::STAT_OK, 2};
		// Missing format chunk: the header values read as zero.
		dir_tab[15] = '{1, 2, 44100, 176400, 4, 16, 4000, 0, 0, 44,
				1, 0, 0, 1, whc_pkg::STAT_MISSING, 0};
		// Negative depth passes the consistency check with a wrapped product.
		dir_tab[16] = '{1, 1, 8, 32'h1FFF_FFFF, 0, 16'hFFFF, 100, 0, 0, 44,
				0, 0, 0, 0, whc_pkg::STAT_OK, 0};
		dir_tab[17] = '{1, 2, 32'hFFFF_FFFF, 32'h1FFF_FFFC, 4, 16, 4096, 0, 0, 44,
				0, 0, 0, 0, whc_pkg::STAT_OK, 0};
		// File ends inside the format fields.
		dir_tab[18] = '{1, 2, 44100, 176400, 4, 16, 4000, 0, 0, 30,
				0, 0, 0, 0, whc_pkg::STAT_OK, 0};
		// Data tag completes on the final byte and so is ignored.
		dir_tab[19] = '{1, 2, 44100, 176400, 4, 16, 4000, 0, 0, 39,
				0, 0, 0, 0, whc_pkg::STAT_OK, 0};
		// Data size bytes lie past the end and count as zero.
		dir_tab[20] = '{1, 2, 44100, 176400, 4, 16, 4000, 0, 0, 40,
				0, 0, 0, 0, whc_pkg::STAT_OK, 0};
		dir_tab[21] = '{1, 2, 44100, 176400, 4, 16, 4000, 0, 0, 1,
				0, 0, 0, 0, whc_pkg::STAT_OK, 0};
		// Data size with its top bit set, padded chunks, trailing samples.
		dir_tab[22] = '{1, 2, 44100, 264600, 6, 24, 32'h8000_0000, 3, 5, 70,
				0, 0, 0, 0, whc_pkg::STAT_OK, 0};
		dir_tab[23] = '{1, 2, 44100, 176400, 4, 16, 4000, 0, 0, 48,
				0, 1, 0, 0, whc_pkg::STAT_OK, 0};
		dir_tab[24] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 20,
				0, 0, 1, 0, whc_pkg::STAT_OK, 0};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (row = 0; row < DIR_ROWS; row++)
			send_file(dir_tab[row]);
		hold_until_drained();

		// Random files, with a stretch where neither side idles.
		bytes_sent = 0;
		file_idx   = 0;
		while (bytes_sent < RANDOM_BYTES || file_idx < RANDOM_FILES) begin
			calm = (file_idx >= 1 && file_idx < 4);
			if (file_idx == 4)
				hold_until_drained();
			send_file(random_wav_file());
			file_idx++;
		end
		calm = 1'b0;

		hold_until_drained();
		repeat (100) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
